[hdl/bfe_pkg.sv]
// shared constants, codes and controller/datapath interface types
`default_nettype none
package bfe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CLK_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int SMP_W      = 24;
  localparam int REQ_W      = 2;
  localparam int NUM_W      = GAIN_W + CLK_W;
  localparam int QUO_W      = GAIN_W + 1;
  localparam int PROD_W     = NUM_W + 2;
  localparam int SPROD_W    = SMP_W + GAIN_W + 1;
  localparam int IN_DATA_W  = 2 * CLK_W + GAIN_W + SMP_W;
  localparam int OUT_BITS   = SMP_W + GAIN_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  typedef struct packed {
    logic latch;
    logic walk_s;
    logic mul;
    logic div_go;
    logic gain;
    logic smul;
    logic sat;
    logic prune;
    logic walk_a;
    logic shift;
    logic walk_r;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic nxt;
    logic hit;
    logic full;
    logic div_done;
    logic shift_end;
    logic prune_end;
    logic last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/bfe_div.sv]
// serial restoring divider for the interpolation step, one quotient bit a cycle
`default_nettype none
module bfe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bfe_pkg::NUM_W-1:0]  num_i,
  input  logic [bfe_pkg::CLK_W-1:0]  den_i,
  output logic [bfe_pkg::QUO_W-1:0]  quo_o,
  output logic                       done_o
);
  import bfe_pkg::*;

  localparam int CW = $clog2(QUO_W + 1);

  logic [CLK_W-1:0] rem_q, rem_d, den_q;
  logic [QUO_W-1:0] sh_q, sh_d;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [CLK_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d = ge ? CLK_W'(trial - {1'b0, den_q}) : trial[CLK_W-1:0];
    sh_d  = {sh_q[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= CLK_W'(num_i[NUM_W-1:QUO_W]);
      sh_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign quo_o  = sh_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[hdl/bfe_datapath.sv]
// breakpoint table, interpolation and scaling datapath with output register
`default_nettype none
module bfe_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfe_pkg::cmd_t                 cmd_i,
  output bfe_pkg::sts_t                 sts_o,
  input  logic [bfe_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic                          in_last_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [bfe_pkg::OUT_DATA_W-1:0] m_data_o,
  output logic                          m_user_o
);
  import bfe_pkg::*;

  localparam int SQ_W = SPROD_W - 15;
  localparam logic signed [SQ_W-1:0] SAT_HI = SQ_W'(8388607);
  localparam logic signed [SQ_W-1:0] SAT_LO = -SQ_W'(8388608);

  logic [CLK_W-1:0]  pt_clk_q  [MAX_POINTS];
  logic [GAIN_W-1:0] pt_gain_q [MAX_POINTS];

  logic [CNT_W-1:0]  count_q, active_q, idx_q, sh_q, kept_q, pn_q, hit_idx_q;
  logic [GAIN_W-1:0] cur_gain_q, pgain_q, g0_q, g1_q;
  logic [CLK_W-1:0]  ev_clk_q, rend_q, c0_q, c1_q;
  logic signed [SMP_W-1:0]   smp_q;
  logic              last_q, found_q, nxt_q, status_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [SPROD_W-1:0] sprod_q;
  logic [SMP_W-1:0]  res_q;
  logic              m_valid_q, m_user_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic [CNT_W-1:0]  rd_ptr, wr_ptr, pn_d;
  logic [CLK_W-1:0]  rd_clk, wr_clk;
  logic [GAIN_W-1:0] rd_gain, wr_gain;
  logic              wr_en, wr_gain_only;
  logic              at_end, gt, eq, in_rng, full;
  logic signed [GAIN_W:0]    gdiff;
  logic signed [CLK_W:0]     dclk;
  logic [PROD_W-1:0]         mag;
  logic [QUO_W-1:0]          quo;
  logic                      div_done;
  logic [GAIN_W+1:0]         gsum;
  logic signed [SPROD_W-1:0] biased;
  logic signed [SQ_W-1:0]    sq;
  logic [SMP_W-1:0]          sat_val;

  // single read port into the table
  assign rd_ptr  = cmd_i.shift ? CNT_W'(sh_q - 1'b1) : idx_q;
  assign rd_clk  = pt_clk_q[rd_ptr[IDX_W-1:0]];
  assign rd_gain = pt_gain_q[rd_ptr[IDX_W-1:0]];

  assign at_end = idx_q == count_q;
  assign gt     = rd_clk > ev_clk_q;
  assign eq     = rd_clk == ev_clk_q;
  assign in_rng = (rd_clk >= ev_clk_q) && (rd_clk < rend_q);
  assign full   = count_q == CNT_W'(MAX_POINTS);
  assign pn_d   = (active_q > count_q) ? count_q : active_q;

  always_comb begin
    sts_o           = '0;
    sts_o.walk_end  = at_end || (cmd_i.walk_s && gt) || (cmd_i.walk_a && (eq || gt));
    sts_o.nxt       = nxt_q;
    sts_o.hit       = !at_end && eq;
    sts_o.full      = full;
    sts_o.div_done  = div_done;
    sts_o.shift_end = sh_q == idx_q;
    sts_o.prune_end = at_end;
    sts_o.last      = last_q;
    sts_o.out_free  = !m_valid_q || m_ready_i;
  end

  always_comb begin
    wr_en        = 1'b0;
    wr_gain_only = 1'b0;
    wr_ptr       = idx_q;
    wr_clk       = rd_clk;
    wr_gain      = rd_gain;
    if (cmd_i.walk_a && !at_end && eq) begin
      wr_gain_only = 1'b1;
      wr_gain      = pgain_q;
    end
    if (cmd_i.shift) begin
      wr_en = 1'b1;
      if (sh_q == idx_q) begin
        wr_clk  = ev_clk_q;
        wr_gain = pgain_q;
      end else begin
        wr_ptr = sh_q;
      end
    end
    if (cmd_i.walk_r && !at_end && !in_rng) begin
      wr_en  = 1'b1;
      wr_ptr = kept_q;
    end
    if (cmd_i.prune && !at_end) begin
      wr_en  = 1'b1;
      wr_ptr = CNT_W'(idx_q - pn_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pt_clk_q[wr_ptr[IDX_W-1:0]]  <= wr_clk;
      pt_gain_q[wr_ptr[IDX_W-1:0]] <= wr_gain;
    end else if (wr_gain_only) begin
      pt_gain_q[wr_ptr[IDX_W-1:0]] <= wr_gain;
    end
  end

  // interpolation arithmetic
  assign gdiff = $signed({1'b0, g1_q}) - $signed({1'b0, g0_q});
  assign dclk  = $signed({1'b0, CLK_W'(ev_clk_q - c0_q)});
  assign mag   = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

  bfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (mag[NUM_W-1:0]),
    .den_i   (CLK_W'(c1_q - c0_q)),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign gsum = {2'b00, g0_q} + (prod_q[PROD_W-1] ? (GAIN_W+2)'(-{1'b0, quo})
                                                  : (GAIN_W+2)'({1'b0, quo}));

  // scale and saturate, truncating toward zero
  assign biased = sprod_q + (sprod_q[SPROD_W-1] ? SPROD_W'(32767) : SPROD_W'(0));
  assign sq     = biased[SPROD_W-1:15];
  always_comb begin
    if (sq > SAT_HI)      sat_val = SAT_HI[SMP_W-1:0];
    else if (sq < SAT_LO) sat_val = SAT_LO[SMP_W-1:0];
    else                  sat_val = sq[SMP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      active_q   <= '0;
      cur_gain_q <= UNITY_GAIN;
      m_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.gain) begin
        if (nxt_q) cur_gain_q <= gsum[GAIN_W-1:0];
        active_q <= found_q ? hit_idx_q : '0;
      end
      if (cmd_i.prune && at_end) begin
        count_q  <= CNT_W'(count_q - pn_q);
        active_q <= '0;
      end
      if (cmd_i.shift && (sh_q == idx_q)) count_q <= count_q + 1'b1;
      if (cmd_i.walk_r && at_end) count_q <= kept_q;
      if (cmd_i.load_out)  m_valid_q <= 1'b1;
      else if (m_ready_i)  m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ev_clk_q <= in_data_i[CLK_W-1:0];
      rend_q   <= in_data_i[2*CLK_W-1:CLK_W];
      pgain_q  <= in_data_i[2*CLK_W+GAIN_W-1:2*CLK_W];
      smp_q    <= in_data_i[IN_DATA_W-1:2*CLK_W+GAIN_W];
      last_q   <= in_last_i;
      idx_q    <= '0;
      kept_q   <= '0;
      found_q  <= 1'b0;
      nxt_q    <= 1'b0;
      res_q    <= '0;
      status_q <= 1'b0;
    end
    if (cmd_i.walk_s && !at_end) begin
      if (gt) begin
        c1_q  <= rd_clk;
        g1_q  <= rd_gain;
        nxt_q <= found_q;
      end else begin
        c0_q      <= rd_clk;
        g0_q      <= rd_gain;
        found_q   <= 1'b1;
        hit_idx_q <= idx_q;
        idx_q     <= idx_q + 1'b1;
      end
    end
    if (cmd_i.mul)  prod_q  <= gdiff * dclk;
    if (cmd_i.smul) sprod_q <= smp_q * $signed({1'b0, cur_gain_q});
    if (cmd_i.sat) begin
      res_q <= sat_val;
      pn_q  <= pn_d;
      idx_q <= pn_d;
    end
    if (cmd_i.prune && !at_end) idx_q <= idx_q + 1'b1;
    if (cmd_i.walk_a) begin
      sh_q <= count_q;
      if (!at_end && !eq && !gt) idx_q <= idx_q + 1'b1;
      if ((at_end || (!eq && gt)) && full) status_q <= 1'b1;
    end
    if (cmd_i.shift && (sh_q != idx_q)) sh_q <= sh_q - 1'b1;
    if (cmd_i.walk_r && !at_end) begin
      idx_q <= idx_q + 1'b1;
      if (!in_rng) kept_q <= kept_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      m_data_q <= OUT_DATA_W'({count_q, cur_gain_q, res_q});
      m_user_q <= status_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

endmodule
`default_nettype wire

[hdl/bfe_ctrl.sv]
// request sequencer state machine
`default_nettype none
module bfe_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [bfe_pkg::REQ_W-1:0] in_req_i,
  output logic                      in_ready_o,
  output bfe_pkg::cmd_t             cmd_o,
  input  bfe_pkg::sts_t             sts_i
);
  import bfe_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_WALK_S = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_DIV_GO = 4'd3;
  localparam logic [3:0] ST_DIV_WT = 4'd4;
  localparam logic [3:0] ST_GAIN   = 4'd5;
  localparam logic [3:0] ST_SMUL   = 4'd6;
  localparam logic [3:0] ST_SAT    = 4'd7;
  localparam logic [3:0] ST_PRUNE  = 4'd8;
  localparam logic [3:0] ST_WALK_A = 4'd9;
  localparam logic [3:0] ST_SHIFT  = 4'd10;
  localparam logic [3:0] ST_WALK_R = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.latch = accept;
        if (accept) begin
          unique case (in_req_i)
            REQ_SAMPLE: state_d = ST_WALK_S;
            REQ_ADD:    state_d = ST_WALK_A;
            REQ_REMOVE: state_d = ST_WALK_R;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_WALK_S: begin
        cmd_o.walk_s = 1'b1;
        if (sts_i.walk_end) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sts_i.nxt ? ST_DIV_GO : ST_GAIN;
      end
      ST_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_DIV_WT;
      end
      ST_DIV_WT: begin
        if (sts_i.div_done) state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = ST_SMUL;
      end
      ST_SMUL: begin
        cmd_o.smul = 1'b1;
        state_d    = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = sts_i.last ? ST_PRUNE : ST_DONE;
      end
      ST_PRUNE: begin
        cmd_o.prune = 1'b1;
        if (sts_i.prune_end) state_d = ST_DONE;
      end
      ST_WALK_A: begin
        cmd_o.walk_a = 1'b1;
        if (sts_i.walk_end) begin
          state_d = (sts_i.hit || sts_i.full) ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_end) state_d = ST_DONE;
      end
      ST_WALK_R: begin
        cmd_o.walk_r = 1'b1;
        if (sts_i.walk_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[hdl/breakpoint_fade_envelope.sv]
// breakpoint_fade_envelope: piecewise-linear gain envelope, top level
//
// slave stream takes one request per transaction: tuser selects sample, add,
// remove or none, tlast marks the end of a read block (prunes on a sample request)
// master stream returns exactly one result per request: scaled sample, current
// gain, point count and the table-full flag
// one request is worked on at a time; the next is taken once its result has
// moved into the output register, even while that result waits for tready
// each add, remove or sample walks the table of stored points (up to 16); an add
//   may then shift later points up to make room, a sample that interpolates runs
//   the serial divider for a 17-bit quotient, and a sample on block end also
//   prunes the points before the current segment
// the table walk reads one breakpoint a cycle through a single read port
// reset empties the table, sets the gain to unity and drops any held result;
// the table contents need no clearing pass
// a stalled receiver holds the result stable and back-pressures the input
`default_nettype none
module breakpoint_fade_envelope (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // event_clock, range_end, point_gain, sample_in
  input  logic [bfe_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [bfe_pkg::REQ_W-1:0]      s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // sample_out, gain_now, point_total, zero pad
  output logic [bfe_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // status
  output logic                           m_axis_tuser_o
);
  import bfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_req_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bfe_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_data_i (s_axis_tdata_i),
    .in_last_i (s_axis_tlast_i),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

[hdl/bfe_checker.sv]
// port-level checker for the envelope and its bind to the top level
`default_nettype none
module bfe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bfe_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tuser_o
);
  import bfe_pkg::*;

  localparam int CNT_LO = SMP_W + GAIN_W;

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid straight out of reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[CNT_LO+CNT_W-1:CNT_LO] <= CNT_W'(MAX_POINTS))
    else $error("point total above table depth");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o
      |-> m_axis_tdata_o[CNT_LO+CNT_W-1:CNT_LO] == CNT_W'(MAX_POINTS))
    else $error("full flag with room left in the table");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready straight after a transaction");

endmodule

bind breakpoint_fade_envelope bfe_checker u_bfe_checker (.*);
`default_nettype wire

[test/tb_breakpoint_fade_envelope.sv]
// self-checking testbench for the breakpoint fade envelope
`timescale 1ns / 1ps
module tb_breakpoint_fade_envelope;
  import bfe_pkg::*;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [CLK_W-1:0]  clk;
    logic [CLK_W-1:0]  rend;
    logic [GAIN_W-1:0] gain;
    logic [SMP_W-1:0]  smp;
    logic              last;
  } req_t;

  typedef struct packed {
    logic [SMP_W-1:0]  smp;
    logic [GAIN_W-1:0] gain;
    logic              full;
    logic [CNT_W-1:0]  total;
  } res_t;

  typedef struct {
    req_t r;
    bit   typed;
    res_t e;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid_i, s_axis_tready_o, s_axis_tlast_i;
  logic [IN_DATA_W-1:0] s_axis_tdata_i;
  logic [REQ_W-1:0] s_axis_tuser_i;
  logic m_axis_tvalid_o, m_axis_tready_i, m_axis_tuser_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  breakpoint_fade_envelope dut (.*);

  logic [CLK_W-1:0]  env_clk[MAX_POINTS];
  logic [GAIN_W-1:0] env_gain[MAX_POINTS];
  int unsigned env_count, env_active;
  logic [GAIN_W-1:0] env_cur;
  res_t result_q[$];
  int errors, n_acc, n_res;
  bit hold_rx;

  function automatic res_t envelope_step(req_t r);
    res_t o;
    int idx, pos, kept, n;
    longint num, den, prod, q;
    bit done;
    o.smp = '0;
    o.full = 1'b0;
    if (r.req == REQ_SAMPLE) begin
      idx = -1;
      for (int i = 0; i < env_count; i++) begin
        if (env_clk[i] > r.clk) break;
        idx = i;
      end
      if (idx >= 0 && idx + 1 < env_count) begin
        num = (longint'(env_gain[idx+1]) - longint'(env_gain[idx])) *
              longint'({32'd0, r.clk - env_clk[idx]});
        den = longint'({32'd0, env_clk[idx+1] - env_clk[idx]});
        if (den > 0) env_cur = GAIN_W'(longint'(env_gain[idx]) + num / den);
      end
      env_active = idx > 0 ? idx : 0;
      prod = longint'($signed(r.smp)) * longint'({48'd0, env_cur});
      q = prod / 32768;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      o.smp = SMP_W'(q);
      if (r.last) begin
        n = env_active > env_count ? env_count : env_active;
        for (int i = n; i < env_count; i++) begin
          env_clk[i-n] = env_clk[i];
          env_gain[i-n] = env_gain[i];
        end
        env_count -= n;
        env_active = 0;
      end
    end else if (r.req == REQ_ADD) begin
      pos = env_count;
      done = 0;
      for (int i = 0; i < env_count; i++) begin
        if (env_clk[i] == r.clk) begin
          env_gain[i] = r.gain;
          done = 1;
          break;
        end
        if (r.clk < env_clk[i]) begin
          pos = i;
          break;
        end
      end
      if (!done) begin
        if (env_count >= MAX_POINTS) o.full = 1'b1;
        else begin
          for (int i = env_count; i > pos; i--) begin
            env_clk[i] = env_clk[i-1];
            env_gain[i] = env_gain[i-1];
          end
          env_clk[pos] = r.clk;
          env_gain[pos] = r.gain;
          env_count++;
        end
      end
    end else if (r.req == REQ_REMOVE) begin
      kept = 0;
      for (int i = 0; i < env_count; i++) begin
        if (env_clk[i] >= r.clk && env_clk[i] < r.rend) continue;
        env_clk[kept] = env_clk[i];
        env_gain[kept] = env_gain[i];
        kept++;
      end
      env_count = kept;
    end
    o.gain = env_cur;
    o.total = CNT_W'(env_count);
    return o;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  function automatic logic [CLK_W-1:0] near_clk();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return CLK_W'($urandom);
    if (k == 1) return CLK_W'(32'hFFFF_FFF0 + $urandom_range(0, 15));
    return CLK_W'($urandom_range(0, 400));
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int k;
    k = $urandom_range(0, 19);
    r.req  = k < 9 ? REQ_SAMPLE : k < 15 ? REQ_ADD : k < 19 ? REQ_REMOVE : REQ_NONE;
    r.clk  = near_clk();
    r.rend = ($urandom_range(0, 5) == 0) ? CLK_W'($urandom)
                                         : CLK_W'(r.clk + $urandom_range(0, 120) - 20);
    r.gain = GAIN_W'($urandom);
    r.smp  = SMP_W'($urandom);
    r.last = $urandom_range(0, 3) == 0;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side
  initial begin
    int g;
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_rx = 0;
      end
      g = gap_len();
      if ($urandom_range(0, 2) == 0 && g > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t a, e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      a.smp   = m_axis_tdata_o[SMP_W-1:0];
      a.gain  = m_axis_tdata_o[SMP_W +: GAIN_W];
      a.total = m_axis_tdata_o[SMP_W+GAIN_W +: CNT_W];
      a.full  = m_axis_tuser_o;
      n_res++;
      if (result_q.size() == 0) begin
        $error("result transaction with none expected");
        errors++;
      end else begin
        e = result_q.pop_front();
        if (a.smp !== e.smp) begin
          $error("sample_out expected %h got %h", e.smp, a.smp); errors++;
        end
        if (a.gain !== e.gain) begin
          $error("gain_now expected %h got %h", e.gain, a.gain); errors++;
        end
        if (a.full !== e.full) begin
          $error("status expected %b got %b", e.full, a.full); errors++;
        end
        if (a.total !== e.total) begin
          $error("point_total expected %0d got %0d", e.total, a.total); errors++;
        end
      end
    end
  end

  task automatic send(req_t r, bit typed, res_t t);
    res_t p;
    p = envelope_step(r);
    if (typed && p != t) begin
      $error("table row disagrees: result expected %h got %h", t, p);
      errors++;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.smp, r.gain, r.rend, r.clk};
    s_axis_tuser_i  <= r.req;
    s_axis_tlast_i  <= r.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    result_q.push_back(typed ? t : p);
    n_acc++;
    @(negedge clk_i);
  endtask

  task automatic drive(req_t r, bit typed, res_t t);
    int g;
    g = gap_len();
    if ($urandom_range(0, 2) == 0 && g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    send(r, typed, t);
  endtask

  row_t rows[$];
  function automatic row_t mk(logic [1:0] q, logic [31:0] c, logic [31:0] e,
                              logic [15:0] g, logic [23:0] s, logic l, bit ty,
                              logic [23:0] es, logic [15:0] eg, logic ef, int et);
    row_t w;
    w.r = '{q, c, e, g, s, l};
    w.typed = ty;
    w.e = '{es, eg, ef, CNT_W'(et)};
    return w;
  endfunction

  initial begin
    req_t r;
    res_t z;
    int cnt;
    errors = 0; n_acc = 0; n_res = 0; hold_rx = 0;
    env_count = 0; env_active = 0; env_cur = UNITY_GAIN;
    z = '0;
    s_axis_tvalid_i = 1'b0; s_axis_tdata_i = '0; s_axis_tuser_i = '0; s_axis_tlast_i = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    rows.push_back(mk(REQ_SAMPLE, 0, 0, 0, 24'h7FFFFF, 0, 1, 24'h7FFFFF, 16'h8000, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 5, 0, 0, 24'h800000, 1, 1, 24'h800000, 16'h8000, 0, 0));
    rows.push_back(mk(REQ_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, 1, 1,
                      0, 16'h8000, 0, 0));
    rows.push_back(mk(REQ_ADD, 100, 0, 16'h0000, 0, 0, 1, 0, 16'h8000, 0, 1));
    rows.push_back(mk(REQ_ADD, 200, 0, 16'hFFFF, 0, 0, 1, 0, 16'h8000, 0, 2));
    rows.push_back(mk(REQ_SAMPLE, 50, 0, 0, 24'h123456, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 150, 0, 0, 24'h7FFFFF, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 199, 0, 0, 24'h800000, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 250, 0, 0, 24'h400000, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_ADD, 200, 0, 16'h4000, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_ADD, 0, 0, 16'h8000, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_ADD, 32'hFFFFFFFF, 0, 16'h1234, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 150, 0, 0, 24'hFFFFFF, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_REMOVE, 300, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_REMOVE, 0, 32'hFFFFFFFF, 0, 0, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 32'hFFFFFFFF, 0, 0, 24'h000001, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < MAX_POINTS + 1; i++)
      rows.push_back(mk(REQ_ADD, 10 * i + 3, 0, 16'(i * 4000), 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_ADD, 13, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(REQ_SAMPLE, 77, 0, 0, 24'h7FFFFF, 1, 0, 0, 0, 0, 0));
    foreach (rows[i]) drive(rows[i].r, rows[i].typed, rows[i].e);

    // sender pauses until everything is back
    s_axis_tvalid_i <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);

    // receiver holds off while the sender keeps offering
    hold_rx = 1;
    fork
      begin
        repeat (6) send(rand_req(), 0, z);
      end
      begin
        wait (!hold_rx);
      end
    join

    for (int i = 0; i < 600; i++) begin
      r = rand_req();
      // occasionally clear the table (all but a point at the top clock value) to keep it lively
      if ($urandom_range(0, 60) == 0) begin
        r.req = REQ_REMOVE; r.clk = 0; r.rend = 32'hFFFFFFFF;
      end
      drive(r, 0, z);
    end
    s_axis_tvalid_i <= 1'b0;

    cnt = 0;
    while (result_q.size() != 0 && cnt < 200000) begin
      @(negedge clk_i);
      cnt++;
    end
    repeat (100) @(negedge clk_i);
    if (result_q.size() != 0) begin
      $error("%0d results never arrived", result_q.size());
      errors++;
    end
    $display("covered %0d requests and %0d results: samples, adds, removes, full table",
             n_acc, n_res);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
